[rtl/core/altitude_cascade_controller_unit_assert.svh]
// Assertion macros shared by the altitude controller RTL.
`ifndef ALTITUDE_CASCADE_CONTROLLER_UNIT_ASSERT_SVH
`define ALTITUDE_CASCADE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ACC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/acc_pkg.sv]
package acc_pkg;

  // field widths
  localparam int TGT_W      = 10;
  localparam int HGT_W      = 13;
  localparam int RATE_W     = 12;
  localparam int LIFT_W     = 13;
  localparam int OUTER_W    = 9;
  localparam int INNER_W    = 13;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FF_W       = 9;
  localparam int GOAL_W     = 9;
  localparam int ERR_W      = 14;
  localparam int DIFF_W     = 15;
  localparam int IERR_W     = 13;
  localparam int TOTAL_W    = 14;

  // fixed constants of the control law
  localparam logic [TGT_W-1:0]   FF_KNEE   = 10'd115;
  localparam logic [FF_W-1:0]    FF_CAP    = 9'd460;
  localparam logic [TGT_W-1:0]   GOAL_CAP  = 10'd470;
  localparam logic [LIFT_W-1:0]  LIFT_MAX  = 13'd8191;
  localparam logic [IERR_W-1:0]  KI_BAND_A = 13'd10;
  localparam logic [IERR_W-1:0]  KI_BAND_B = 13'd20;
  localparam logic [IERR_W-1:0]  KI_BAND_C = 13'd30;
  localparam logic [IERR_W-1:0]  KI_BAND_D = 13'd50;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_OUTER_KP  = 16'd9830;
  localparam logic [GAIN_W-1:0] RST_OUTER_KD  = 16'd5243;
  localparam logic [GAIN_W-1:0] RST_INNER_KP  = 16'd39322;
  localparam logic [LIM_W-1:0]  RST_OUTER_LIM = 8'd60;
  localparam logic [LIM_W-1:0]  RST_INTEG_MAX = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_KP,
    REG_OUTER_KD,
    REG_INNER_KP,
    REG_OUTER_LIMIT,
    REG_INTEG_MAX
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] outer_kp;
    logic [GAIN_W-1:0] outer_kd;
    logic [GAIN_W-1:0] inner_kp;
    logic [LIM_W-1:0]  outer_limit;
    logic [LIM_W-1:0]  integrator_max;
  } cfg_regs_t;

  // microcode fields
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_ERR,
    MUL_KD_DIFF,
    MUL_KI_IERR,
    MUL_IKP_IERR
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_ACC_PROD,
    ALU_ADD_PROD,
    ALU_OUTER,
    ALU_IERR,
    ALU_INTEG,
    ALU_INNER_SUM,
    ALU_INNER,
    ALU_EMIT
  } alu_op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_WAIT_OUT
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE      = 4'd0;
  localparam step_t ST_MUL_KP    = 4'd1;
  localparam step_t ST_MUL_KD    = 4'd2;
  localparam step_t ST_PD_SUM    = 4'd3;
  localparam step_t ST_OUTER     = 4'd4;
  localparam step_t ST_IERR      = 4'd5;
  localparam step_t ST_MUL_KI    = 4'd6;
  localparam step_t ST_MUL_IKP   = 4'd7;
  localparam step_t ST_INNER_SUM = 4'd8;
  localparam step_t ST_INNER     = 4'd9;
  localparam step_t ST_EMIT      = 4'd10;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    cond_t    cond;
    step_t    target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_hold;
  } seq_status_t;

  // control store; target is taken when the step's condition passes
  function automatic ctrl_word_t prog_word(input step_t s);
    ctrl_word_t w;
    case (s)
      ST_IDLE:      w = '{MUL_NONE,     ALU_LOAD,      COND_WAIT_IN,  ST_MUL_KP};
      ST_MUL_KP:    w = '{MUL_KP_ERR,   ALU_NOP,       COND_NEXT,     ST_MUL_KD};
      ST_MUL_KD:    w = '{MUL_KD_DIFF,  ALU_ACC_PROD,  COND_NEXT,     ST_PD_SUM};
      ST_PD_SUM:    w = '{MUL_NONE,     ALU_ADD_PROD,  COND_NEXT,     ST_OUTER};
      ST_OUTER:     w = '{MUL_NONE,     ALU_OUTER,     COND_NEXT,     ST_IERR};
      ST_IERR:      w = '{MUL_NONE,     ALU_IERR,      COND_NEXT,     ST_MUL_KI};
      ST_MUL_KI:    w = '{MUL_KI_IERR,  ALU_NOP,       COND_NEXT,     ST_MUL_IKP};
      ST_MUL_IKP:   w = '{MUL_IKP_IERR, ALU_INTEG,     COND_NEXT,     ST_INNER_SUM};
      ST_INNER_SUM: w = '{MUL_NONE,     ALU_INNER_SUM, COND_NEXT,     ST_INNER};
      ST_INNER:     w = '{MUL_NONE,     ALU_INNER,     COND_NEXT,     ST_EMIT};
      ST_EMIT:      w = '{MUL_NONE,     ALU_EMIT,      COND_WAIT_OUT, ST_IDLE};
      default:      w = '{MUL_NONE,     ALU_NOP,       COND_NEXT,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/acc_in_if.sv]
interface acc_in_if;
  import acc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TGT_W-1:0]         target_throttle;
  logic [HGT_W-1:0]         height_mm;
  logic signed [RATE_W-1:0] climb_rate;

  modport source (output valid, output target_throttle, output height_mm,
                  output climb_rate, input ready);
  modport sink   (input valid, input target_throttle, input height_mm,
                  input climb_rate, output ready);
endinterface

[rtl/core/acc_out_if.sv]
interface acc_out_if;
  import acc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LIFT_W-1:0]         lift_command;
  logic signed [OUTER_W-1:0] outer_demand;
  logic signed [INNER_W-1:0] inner_demand;

  modport source (output valid, output lift_command, output outer_demand,
                  output inner_demand, input ready);
  modport sink   (input valid, input lift_command, input outer_demand,
                  input inner_demand, output ready);
endinterface

[rtl/core/acc_seq.sv]
module acc_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  acc_pkg::seq_status_t status,
  output acc_pkg::ctrl_word_t  ctrl,
  output logic                 go
);
  import acc_pkg::*;

  step_t step;
  step_t step_next;

  assign ctrl = prog_word(step);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     go = 1'b1;
      COND_WAIT_IN:  go = status.in_valid;
      COND_WAIT_OUT: go = !status.out_hold;
      default:       go = 1'b0;
    endcase
    step_next = go ? ctrl.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[rtl/core/acc_dp.sv]
module acc_dp #(
  parameter int DIFF_LAG       = 3,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  acc_pkg::cfg_regs_t                cfg,
  input  acc_pkg::ctrl_word_t               ctrl,
  input  logic                              go,
  input  logic [acc_pkg::TGT_W-1:0]         target_throttle,
  input  logic [acc_pkg::HGT_W-1:0]         height_mm,
  input  logic signed [acc_pkg::RATE_W-1:0] climb_rate,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [acc_pkg::LIFT_W-1:0]        lift_command,
  output logic signed [acc_pkg::OUTER_W-1:0] outer_demand,
  output logic signed [acc_pkg::INNER_W-1:0] inner_demand
);
  import acc_pkg::*;

  localparam int F   = GAIN_FRAC_BITS;
  localparam int DW  = F + 24;             // accumulator / product width
  localparam int QW  = DW - F;             // integer part after the shift
  localparam int IW  = F + 8;              // integrator width
  localparam int AW  = (F > 16) ? F : 16;  // unsigned multiplier operand
  localparam int MW  = AW + 1 + DIFF_W;    // full product width
  localparam int ONE  = 1 << F;
  localparam int KI_A = (ONE + 10) / 20;
  localparam int KI_B = (ONE + 12) / 25;
  localparam int KI_C = (ONE + 25) / 50;
  localparam int KI_D = (7 * ONE + 500) / 1000;
  localparam int KI_E = (ONE + 5000) / 10000;
  localparam logic [DW-1:0] ONE_M1 = {{(DW-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [QW-1:0] INNER_HI = QW'(4095);
  localparam logic signed [QW-1:0] INNER_LO = -QW'(4096);

  // working registers
  logic signed [ERR_W-1:0]   hist [DIFF_LAG];
  logic [IW-1:0]             integ;
  logic [FF_W-1:0]           ff;
  logic signed [RATE_W-1:0]  rate;
  logic signed [ERR_W-1:0]   err0;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DW-1:0]      prod;
  logic signed [DW-1:0]      acc;
  logic signed [OUTER_W-1:0] outer;
  logic signed [IERR_W-1:0]  ierr;
  logic signed [INNER_W-1:0] inner;

  // combinational terms
  logic [GOAL_W-1:0]          goal_c;
  logic [FF_W-1:0]            ff_c;
  logic signed [ERR_W-1:0]    err0_c;
  logic signed [DIFF_W-1:0]   diff_c;
  logic [AW-1:0]              mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [MW-1:0]       mul_full;
  logic [IERR_W-1:0]          ierr_abs;
  logic signed [QW-1:0]       lim_q;
  logic signed [QW-1:0]       acc_q;
  logic signed [OUTER_W-1:0]  outer_c;
  logic signed [IERR_W-1:0]   ierr_c;
  logic [IW-1:0]              imax_fx;
  logic signed [DW-1:0]       integ_sum;
  logic [IW-1:0]              integ_c;
  logic [IW-1:0]              int_part_fx;
  logic signed [DW-1:0]       inner_sum;
  logic signed [INNER_W-1:0]  inner_c;
  logic signed [TOTAL_W-1:0]  total;
  logic [LIFT_W-1:0]          tot_pos;
  logic [LIFT_W+1:0]          lift4;
  logic [LIFT_W-1:0]          lift_c;

  // truncate toward zero while dropping F fraction bits
  function automatic logic signed [QW-1:0] trunc_q(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] adj;
    adj = v[DW-1] ? v + $signed(ONE_M1) : v;
    return adj[DW-1:F];
  endfunction

  always_comb begin
    // item load: feedforward, capped goal, error and lagged difference
    ff_c   = (target_throttle < FF_KNEE) ? {target_throttle[6:0], 2'b00} : FF_CAP;
    goal_c = (target_throttle > GOAL_CAP) ? GOAL_CAP[GOAL_W-1:0]
                                          : target_throttle[GOAL_W-1:0];
    err0_c = $signed({5'b0, goal_c}) - $signed({1'b0, height_mm});
    diff_c = $signed({err0_c[ERR_W-1], err0_c})
           - $signed({hist[DIFF_LAG-1][ERR_W-1], hist[DIFF_LAG-1]});

    // scheduled integral gain
    ierr_abs = ierr[IERR_W-1] ? IERR_W'(-ierr) : IERR_W'(ierr);

    // shared multiplier operand select
    case (ctrl.mul_sel)
      MUL_KP_ERR: begin
        mul_a = AW'(cfg.outer_kp);
        mul_b = DIFF_W'(err0);
      end
      MUL_KD_DIFF: begin
        mul_a = AW'(cfg.outer_kd);
        mul_b = diff;
      end
      MUL_KI_IERR: begin
        if (ierr_abs < KI_BAND_A)      mul_a = AW'(KI_A);
        else if (ierr_abs < KI_BAND_B) mul_a = AW'(KI_B);
        else if (ierr_abs < KI_BAND_C) mul_a = AW'(KI_C);
        else if (ierr_abs < KI_BAND_D) mul_a = AW'(KI_D);
        else                           mul_a = AW'(KI_E);
        mul_b = DIFF_W'(ierr);
      end
      MUL_IKP_IERR: begin
        mul_a = AW'(cfg.inner_kp);
        mul_b = DIFF_W'(ierr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = $signed({1'b0, mul_a}) * mul_b;

    // shared truncation of the accumulator
    acc_q = trunc_q(acc);

    // outer clamp
    lim_q = $signed({{(QW-LIM_W){1'b0}}, cfg.outer_limit});
    if (acc_q > lim_q)       outer_c = lim_q[OUTER_W-1:0];
    else if (acc_q < -lim_q) outer_c = OUTER_W'(-lim_q);
    else                     outer_c = acc_q[OUTER_W-1:0];

    ierr_c = $signed({{(IERR_W-OUTER_W){outer[OUTER_W-1]}}, outer})
           - $signed({rate[RATE_W-1], rate});

    // integrator update, clamped to 0..max
    imax_fx   = {cfg.integrator_max, {F{1'b0}}};
    integ_sum = $signed({{(DW-IW){1'b0}}, integ}) + prod;
    if (integ_sum[DW-1])
      integ_c = '0;
    else if (integ_sum > $signed({{(DW-IW){1'b0}}, imax_fx}))
      integ_c = imax_fx;
    else
      integ_c = integ_sum[IW-1:0];

    int_part_fx = {integ[IW-1:F], {F{1'b0}}};
    inner_sum   = prod + $signed({{(DW-IW){1'b0}}, int_part_fx});

    if (acc_q > INNER_HI)      inner_c = INNER_HI[INNER_W-1:0];
    else if (acc_q < INNER_LO) inner_c = INNER_LO[INNER_W-1:0];
    else                       inner_c = acc_q[INNER_W-1:0];

    // lift: 4*max(0, ff+inner), saturated
    total   = $signed({5'b0, ff}) + $signed({inner[INNER_W-1], inner});
    tot_pos = total[TOTAL_W-1] ? '0 : total[LIFT_W-1:0];
    lift4   = {tot_pos, 2'b00};
    lift_c  = (lift4 > {2'b00, LIFT_MAX}) ? LIFT_MAX : lift4[LIFT_W-1:0];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      case (ctrl.mul_sel)
        MUL_NONE: ;
        default:  prod <= DW'(mul_full);
      endcase
      case (ctrl.alu_op)
        ALU_LOAD: begin
          ff   <= ff_c;
          rate <= climb_rate;
          err0 <= err0_c;
          diff <= diff_c;
        end
        ALU_ACC_PROD:  acc   <= prod;
        ALU_ADD_PROD:  acc   <= acc + prod;
        ALU_OUTER:     outer <= outer_c;
        ALU_IERR:      ierr  <= ierr_c;
        ALU_INNER_SUM: acc   <= inner_sum;
        ALU_INNER:     inner <= inner_c;
        ALU_EMIT: begin
          lift_command <= lift_c;
          outer_demand <= outer;
          inner_demand <= inner;
        end
        default: ;
      endcase
    end
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIFF_LAG; i++) begin
        hist[i] <= '0;
      end
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go && ctrl.alu_op == ALU_LOAD) begin
        for (int i = DIFF_LAG - 1; i > 0; i--) begin
          hist[i] <= hist[i-1];
        end
        hist[0] <= err0_c;
      end
      if (go && ctrl.alu_op == ALU_INTEG) begin
        integ <= integ_c;
      end
      if (go && ctrl.alu_op == ALU_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/altitude_cascade_controller_unit.sv]
// Channel  | Dir | Fields                                          | Handshake
// ---------+-----+-------------------------------------------------+-----------
// sample   | in  | target_throttle, height_mm, climb_rate          | valid/ready
// command  | out | lift_command, outer_demand, inner_demand        | valid/ready
// cfg      | in  | cfg_addr, cfg_wdata                             | cfg_wr_en
//
// From accept to the next accept the microcode runs ten steps after the idle
// step, and four products share one multiplier. The result is held in an output
// register; the next item is taken while it waits. Synchronous active-high
// reset clears the step counter, error history, integrator and output valid,
// and loads the config registers with their defaults; no item is taken while
// reset is high. A result not taken holds the sequencer on its emit step.
`include "altitude_cascade_controller_unit_assert.svh"

module altitude_cascade_controller_unit #(
  parameter int DIFF_LAG       = 3,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  acc_in_if.sink                          sample,
  acc_out_if.source                       command,
  input  logic                            cfg_wr_en,
  input  logic [acc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [acc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import acc_pkg::*;

  cfg_regs_t   cfg;
  ctrl_word_t  ctrl;
  seq_status_t status;
  logic        go;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_kp       <= RST_OUTER_KP;
      cfg.outer_kd       <= RST_OUTER_KD;
      cfg.inner_kp       <= RST_INNER_KP;
      cfg.outer_limit    <= RST_OUTER_LIM;
      cfg.integrator_max <= RST_INTEG_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_OUTER_KP:    cfg.outer_kp       <= cfg_wdata[GAIN_W-1:0];
        REG_OUTER_KD:    cfg.outer_kd       <= cfg_wdata[GAIN_W-1:0];
        REG_INNER_KP:    cfg.inner_kp       <= cfg_wdata[GAIN_W-1:0];
        REG_OUTER_LIMIT: cfg.outer_limit    <= cfg_wdata[LIM_W-1:0];
        REG_INTEG_MAX:   cfg.integrator_max <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer status: input pending, or a result still unread
  assign status.in_valid = sample.valid;
  assign status.out_hold = command.valid && !command.ready;

  // only the idle step waits on the input
  assign sample.ready = !rst && (ctrl.cond == COND_WAIT_IN);

  acc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .go     (go)
  );

  acc_dp #(
    .DIFF_LAG       (DIFF_LAG),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ctrl            (ctrl),
    .go              (go),
    .target_throttle (sample.target_throttle),
    .height_mm       (sample.height_mm),
    .climb_rate      (sample.climb_rate),
    .out_ready       (command.ready),
    .out_valid       (command.valid),
    .lift_command    (command.lift_command),
    .outer_demand    (command.outer_demand),
    .inner_demand    (command.inner_demand)
  );

  // outer clamp bounds for checking
  logic signed [OUTER_W:0] lim_pos;
  logic signed [OUTER_W:0] lim_neg;
  logic signed [OUTER_W:0] outer_x;

  assign lim_pos = $signed({2'b00, cfg.outer_limit});
  assign lim_neg = -lim_pos;
  assign outer_x = $signed({command.outer_demand[OUTER_W-1], command.outer_demand});

  `ACC_ASSERT_NEXT(a_single_item, clk, rst, sample.valid && sample.ready, !sample.ready, "second item accepted mid-sequence")
  `ACC_ASSERT_NOW(a_outer_in_limit, clk, rst, command.valid, (outer_x <= lim_pos) && (outer_x >= lim_neg), "outer demand outside limit")
  `ACC_ASSERT_NOW(a_lift_step, clk, rst, command.valid, (command.lift_command[1:0] == 2'b00) || (command.lift_command == LIFT_MAX), "lift not a multiple of four")

endmodule
